// ===== rtl/rfc_pkg.sv =====
package rfc_pkg;

  localparam int RATIO_W    = 40;
  localparam int OPND_W     = 16;
  localparam int TOL_W      = 24;
  localparam int TERMS_W    = 4;
  localparam int FRAC_OUT_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [TOL_W-1:0]   TOL_RESET   = 24'd168;
  localparam logic [TERMS_W-1:0] TERMS_RESET = 4'd5;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TERMS = 1'b1;

  typedef enum logic [2:0] {
    MUL_FRAC_D,
    MUL_WHOLE_D,
    MUL_TOL_D,
    MUL_TOL_Q,
    MUL_D_A
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     cap_round;
    logic     cap_n;
    logic     count_inc;
    logic     div_start;
    logic     div_op1;
    logic     d_update;
    logic     finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op1;
    logic zero_den;
    logic div_done;
    logic more;
    logic pass;
  } ctrl_status_t;

endpackage

// ===== rtl/rfc_divider.sv =====
module rfc_divider #(
  parameter int DW = 41
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CNTW = $clog2(DW + 1);

  logic [CNTW-1:0] cnt;
  logic            running;
  logic [DW:0]     trial;
  logic            ge;

  assign trial = {remainder, quotient[DW-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNTW'(DW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Restoring division: one quotient bit per cycle, shifted in behind the dividend.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (running) begin
      quotient  <= {quotient[DW-2:0], ge};
      remainder <= ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
    end
  end

endmodule

// ===== rtl/rfc_datapath.sv =====
module rfc_datapath #(
  parameter int FRAC_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [rfc_pkg::CFG_DATA_W-1:0]    wr_data,
  input  logic                              opcode,
  input  logic [rfc_pkg::RATIO_W-1:0]       ratio_in,
  input  logic [rfc_pkg::OPND_W-1:0]        numerator_in,
  input  logic [rfc_pkg::OPND_W-1:0]        denominator_in,
  input  rfc_pkg::ctrl_cmd_t                cmd,
  output rfc_pkg::ctrl_status_t             status,
  output logic                              done,
  output logic [rfc_pkg::RATIO_W-1:0]       ratio_out,
  output logic [rfc_pkg::FRAC_OUT_W-1:0]    numerator_out,
  output logic [rfc_pkg::FRAC_OUT_W-1:0]    denominator_out,
  output logic                              zero_divisor,
  output logic                              saturated
);
  import rfc_pkg::*;

  localparam int QW  = FRAC_BITS + 1;
  localparam int WW  = RATIO_W - FRAC_BITS;
  localparam int MW  = (QW > TOL_W) ? QW : TOL_W;
  localparam int PW  = MW + QW;
  localparam int DW  = FRAC_BITS + OPND_W + 1;
  localparam int NW  = WW + QW + 1;
  localparam int XW  = (DW > RATIO_W) ? DW : RATIO_W;
  localparam int SW  = (NW > FRAC_OUT_W) ? NW : FRAC_OUT_W;
  localparam int DSW = (QW > FRAC_OUT_W) ? QW : FRAC_OUT_W;

  logic [TOL_W-1:0]   tolerance;
  logic [TERMS_W-1:0] max_terms;

  logic                 opcode_r;
  logic [RATIO_W-1:0]   ratio_r;
  logic [OPND_W-1:0]    num_r;
  logic [OPND_W-1:0]    den_r;
  logic [QW-1:0]        q_r;
  logic [QW-1:0]        rem_r;
  logic [QW-1:0]        d_r;
  logic [QW-1:0]        dprev_r;
  logic [TERMS_W-1:0]   count_r;
  logic [PW-1:0]        prod_r;
  logic [QW-1:0]        k_r;
  logic [QW-1:0]        err_r;
  logic [NW-1:0]        n_r;

  logic [MW-1:0]        mul_a;
  logic [QW-1:0]        mul_b;
  logic [PW-1:0]        mul_p;
  logic [FRAC_BITS-1:0] low;
  logic                 round_up;
  logic [QW-1:0]        k_next;
  logic [QW-1:0]        err_next;
  logic [DW-1:0]        div_dividend;
  logic [DW-1:0]        div_divisor;
  logic                 div_done;
  logic [DW-1:0]        div_quo;
  logic [DW-1:0]        div_rem;
  logic                 q_big;
  logic                 n_big;
  logic                 d_big;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      max_terms <= TERMS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_TOLERANCE: tolerance <= wr_data[TOL_W-1:0];
        REG_MAX_TERMS: max_terms <= wr_data[TERMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = d_r;
    case (cmd.mul_sel)
      MUL_FRAC_D:  mul_a = MW'(ratio_r[FRAC_BITS-1:0]);
      MUL_WHOLE_D: mul_a = MW'(ratio_r[RATIO_W-1:FRAC_BITS]);
      MUL_TOL_D:   mul_a = MW'(tolerance);
      MUL_TOL_Q: begin
        mul_a = MW'(tolerance);
        mul_b = q_r;
      end
      MUL_D_A:     mul_a = MW'(div_quo[QW-1:0]);
      default: ;
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Round the scaled fraction to nearest, halves up, and keep the distance to it.
  assign low      = prod_r[FRAC_BITS-1:0];
  assign round_up = low[FRAC_BITS-1];
  assign k_next   = QW'(prod_r >> FRAC_BITS) + QW'(round_up);
  assign err_next = round_up ? ((QW'(1) << FRAC_BITS) - QW'(low)) : QW'(low);

  assign div_dividend = cmd.div_op1 ? DW'(q_r)
                                    : ((DW'(num_r) << FRAC_BITS) + DW'(den_r >> 1));
  assign div_divisor  = cmd.div_op1 ? DW'(rem_r) : DW'(den_r);

  rfc_divider #(.DW(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode_r <= opcode;
      ratio_r  <= ratio_in;
      num_r    <= numerator_in;
      den_r    <= denominator_in;
      q_r      <= QW'(1) << FRAC_BITS;
      rem_r    <= QW'(ratio_in[FRAC_BITS-1:0]);
      d_r      <= QW'(1);
      dprev_r  <= '0;
      count_r  <= TERMS_W'(1);
    end
    // Convergent denominators never exceed 2^FRAC_BITS, so the low bits are exact.
    if (cmd.d_update) begin
      d_r     <= prod_r[QW-1:0] + dprev_r;
      dprev_r <= d_r;
      q_r     <= rem_r;
      rem_r   <= div_rem[QW-1:0];
    end
    if (cmd.count_inc) begin
      count_r <= count_r + 1'b1;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_p;
    end
    if (cmd.cap_round) begin
      k_r   <= k_next;
      err_r <= err_next;
    end
    if (cmd.cap_n) begin
      n_r <= NW'(prod_r) + NW'(k_r);
    end
  end

  assign status.op1      = opcode_r;
  assign status.zero_den = (den_r == '0);
  assign status.div_done = div_done;
  assign status.more     = (count_r < max_terms) && (PW'(err_r) > prod_r);
  assign status.pass     = PW'({rem_r, {FRAC_BITS{1'b0}}}) > prod_r;

  assign q_big = XW'(div_quo) > XW'({RATIO_W{1'b1}});
  assign n_big = SW'(n_r) > SW'({FRAC_OUT_W{1'b1}});
  assign d_big = DSW'(d_r) > DSW'({FRAC_OUT_W{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (!opcode_r) begin
        numerator_out   <= '0;
        denominator_out <= FRAC_OUT_W'(1);
        zero_divisor    <= (den_r == '0);
        saturated       <= (den_r != '0) && q_big;
        if (den_r == '0) begin
          ratio_out <= '0;
        end else begin
          ratio_out <= q_big ? {RATIO_W{1'b1}} : RATIO_W'(div_quo);
        end
      end else begin
        ratio_out       <= '0;
        numerator_out   <= n_big ? {FRAC_OUT_W{1'b1}} : FRAC_OUT_W'(n_r);
        denominator_out <= d_big ? {FRAC_OUT_W{1'b1}} : FRAC_OUT_W'(d_r);
        zero_divisor    <= 1'b0;
        saturated       <= n_big || d_big;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    done && zero_divisor |-> (ratio_out == '0) && !saturated)
    else $error("zero divisor result carries a ratio or saturation");
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (denominator_out != '0))
    else $error("result denominator is zero");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (div_divisor != '0))
    else $error("divider started with a zero divisor");
`endif

endmodule

// ===== rtl/rfc_ctrl.sv =====
module rfc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  rfc_pkg::ctrl_status_t status,
  output rfc_pkg::ctrl_cmd_t    cmd
);
  import rfc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FRAC,
    S_WHOLE,
    S_TOLD,
    S_CHECK,
    S_TEST,
    S_DIV,
    S_DUPD,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.mul_sel   = MUL_FRAC_D;
    cmd.div_op1   = status.op1;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.op1) begin
          state_next = S_FRAC;
        end else if (status.zero_den) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_FRAC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FRAC_D;
        state_next  = S_WHOLE;
      end
      S_WHOLE: begin
        cmd.cap_round = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_WHOLE_D;
        state_next    = S_TOLD;
      end
      S_TOLD: begin
        cmd.cap_n   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TOL_D;
        state_next  = S_CHECK;
      end
      S_CHECK: begin
        if (status.more) begin
          cmd.count_inc = 1'b1;
          cmd.mul_en    = 1'b1;
          cmd.mul_sel   = MUL_TOL_Q;
          state_next    = S_TEST;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_TEST: begin
        if (status.pass) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          if (status.op1) begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_D_A;
            state_next  = S_DUPD;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_DUPD: begin
        cmd.d_update = 1'b1;
        state_next   = S_FRAC;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/ratio_fraction_converter.sv =====
// Opcode 0 (divide): after the start transfer the controller loads the operands, starts the
// bit-serial divider and registers its quotient; a zero divisor skips the divider.
// Opcode 1 (approximate): a convergent loop of up to max_terms-1 steps, each of one serial
// division and five multiplications; the remainder test can end refinement early. One item
// at a time: busy is high from the start transfer until the strobe cycle; the receiver cannot
// stall. Synchronous reset restores both registers.
module ratio_fraction_converter #(
  parameter int FRAC_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [rfc_pkg::CFG_DATA_W-1:0]    wr_data,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode,
  input  logic [rfc_pkg::RATIO_W-1:0]       ratio_in,
  input  logic [rfc_pkg::OPND_W-1:0]        numerator_in,
  input  logic [rfc_pkg::OPND_W-1:0]        denominator_in,
  output logic                              done,
  output logic [rfc_pkg::RATIO_W-1:0]       ratio_out,
  output logic [rfc_pkg::FRAC_OUT_W-1:0]    numerator_out,
  output logic [rfc_pkg::FRAC_OUT_W-1:0]    denominator_out,
  output logic                              zero_divisor,
  output logic                              saturated
);
  import rfc_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  rfc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  rfc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .opcode          (opcode),
    .ratio_in        (ratio_in),
    .numerator_in    (numerator_in),
    .denominator_in  (denominator_in),
    .cmd             (cmd),
    .status          (status),
    .done            (done),
    .ratio_out       (ratio_out),
    .numerator_out   (numerator_out),
    .denominator_out (denominator_out),
    .zero_divisor    (zero_divisor),
    .saturated       (saturated)
  );

endmodule
